@@ design/mbe_pkg.sv @@
// Shared types, constants and register codes of the Mandelbrot escape-time core.
package mbe_pkg;

   // Field widths fixed by the interface.
   localparam int COL_W    = 10;
   localparam int ROW_W    = 10;
   localparam int COUNT_W  = 16;
   localparam int ORIGIN_W = 32;
   localparam int STEP_W   = 31;

   // Default number of fraction bits; the datapath is FRAC_BITS + 4 bits wide.
   localparam int FRAC_BITS_DEFAULT = 28;

   // View size; pixel indices wrap modulo these powers of two.
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;

   // Depth of the queue between the front end and the iteration engine.
   localparam int QUEUE_DEPTH = 4;

   // Register port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic signed [ORIGIN_W-1:0] ORIGIN_RE_RESET = -32'sd536870912;
   localparam logic signed [ORIGIN_W-1:0] ORIGIN_IM_RESET = -32'sd268435456;
   localparam logic [STEP_W-1:0]          STEP_RE_RESET   = 31'd786432;
   localparam logic [STEP_W-1:0]          STEP_IM_RESET   = 31'd524288;
   localparam logic [COUNT_W-1:0]         MAX_ITER_RESET  = 16'd128;

   typedef enum logic [2:0] {
      REG_ORIGIN_RE      = 3'd0,
      REG_ORIGIN_IM      = 3'd1,
      REG_STEP_RE        = 3'd2,
      REG_STEP_IM        = 3'd3,
      REG_MAX_ITERATIONS = 3'd4
   } mbe_reg_type;

   typedef struct packed {
      logic signed [ORIGIN_W-1:0] origin_re;
      logic signed [ORIGIN_W-1:0] origin_im;
      logic [STEP_W-1:0]          step_re;
      logic [STEP_W-1:0]          step_im;
      logic [COUNT_W-1:0]         max_iterations;
   } mbe_cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
   } mbe_req_type;

   typedef struct packed {
      logic [COL_W-1:0]   out_column;
      logic [ROW_W-1:0]   out_row;
      logic [COUNT_W-1:0] iteration_count;
   } mbe_rsp_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SQUARE,
      BACK_UPDATE,
      BACK_DONE
   } mbe_back_state_type;

endpackage

@@ design/mandelbrot_escape_time_core.sv @@
// Top level of the Mandelbrot escape-time core: register file and block wiring.
//
// Each request names one pixel by column and row; the core forms
// c = origin + index * step in signed fixed point (FRAC_BITS fraction bits,
// four integer bits), iterates z = z*z + c from zero and returns the pixel
// with the number of updates made before |z|^2 exceeded 4, or max_iterations
// if it never did. The front end registers each request and forms c from it,
// can take a new request every cycle unless the queue is full, and hands c
// to a four-entry queue; each iteration of the engine behind it runs a square
// step (limit check, the two squares and the cross product) and then an update
// step (escape test and update). The engine works on one pixel at a time and
// sets the sustained rate. Results keep request order. Registers sit at byte
// addresses 0x00 origin_re, 0x04 origin_im, 0x08 step_re, 0x0C step_im, 0x10
// max_iterations, and are to be written only while no request is in flight.
module mandelbrot_escape_time_core #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mbe_pkg::mbe_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mbe_pkg::mbe_rsp_type          rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mbe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbe_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbe_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import mbe_pkg::*;

   localparam int DataW  = FRAC_BITS + 4;
   localparam int EntryW = 2 * DataW + COL_W + ROW_W;

   mbe_cfg_type      cfg_ff, cfg_in;
   mbe_reg_type      reg_index;
   logic             csr_write;
   logic             queue_full, queue_empty, queue_push, queue_pop;
   logic [EntryW-1:0] queue_in_data, queue_out_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = mbe_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_ORIGIN_RE:      cfg_in.origin_re      = csr_pwdata;
            REG_ORIGIN_IM:      cfg_in.origin_im      = csr_pwdata;
            REG_STEP_RE:        cfg_in.step_re        = csr_pwdata[STEP_W-1:0];
            REG_STEP_IM:        cfg_in.step_im        = csr_pwdata[STEP_W-1:0];
            REG_MAX_ITERATIONS: cfg_in.max_iterations = csr_pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ORIGIN_RE:      csr_prdata = cfg_ff.origin_re;
         REG_ORIGIN_IM:      csr_prdata = cfg_ff.origin_im;
         REG_STEP_RE:        csr_prdata = CSR_DATA_W'(cfg_ff.step_re);
         REG_STEP_IM:        csr_prdata = CSR_DATA_W'(cfg_ff.step_im);
         REG_MAX_ITERATIONS: csr_prdata = CSR_DATA_W'(cfg_ff.max_iterations);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_re: ORIGIN_RE_RESET, origin_im: ORIGIN_IM_RESET,
                     step_re: STEP_RE_RESET, step_im: STEP_IM_RESET,
                     max_iterations: MAX_ITER_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbe_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_in_data)
   );

   mbe_queue #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_out_data),
      .empty     (queue_empty)
   );

   mbe_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .queue_data  (queue_out_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

@@ design/mbe_front.sv @@
// Front end: accepts pixel requests and forms the point c for each one.
module mbe_front #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbe_pkg::mbe_cfg_type    cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mbe_pkg::mbe_req_type    req_data,
   input  logic                    queue_full,
   output logic                    queue_push,
   output logic [2*(FRAC_BITS+4)+mbe_pkg::COL_W+mbe_pkg::ROW_W-1:0] queue_data
);
   import mbe_pkg::*;

   localparam int DataW = FRAC_BITS + 4;
   localparam int ProdW = COL_W + STEP_W;
   localparam int BaseW = ((ProdW + 1 > ORIGIN_W) ? ProdW + 1 : ORIGIN_W) + 1;
   localparam int SumW  = (DataW + 1 > BaseW) ? DataW + 1 : BaseW;
   localparam logic signed [SumW-1:0] QHi = {{(SumW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
   localparam logic signed [SumW-1:0] QLo = ~QHi;
   localparam int ColMask = MAX_COLUMNS - 1;
   localparam int RowMask = MAX_ROWS - 1;

   logic                   hold_valid_ff, hold_valid_in;
   logic [COL_W-1:0]       hold_col_ff, hold_col_in;
   logic [ROW_W-1:0]       hold_row_ff, hold_row_in;
   logic [ProdW-1:0]       prod_re_ff, prod_re_in;
   logic [ProdW-1:0]       prod_im_ff, prod_im_in;
   logic                   accept;
   logic signed [SumW-1:0] sum_re, sum_im;
   logic signed [DataW-1:0] c_re, c_im;

   assign req_stall  = hold_valid_ff & queue_full;
   assign accept     = req_valid & ~req_stall;
   assign queue_push = hold_valid_ff & ~queue_full;

   // Indices wrap modulo the view size, which is a power of two.
   assign hold_col_in   = req_data.column & ColMask[COL_W-1:0];
   assign hold_row_in   = req_data.row & RowMask[ROW_W-1:0];
   assign prod_re_in    = ProdW'(hold_col_in) * ProdW'(cfg.step_re);
   assign prod_im_in    = ProdW'(hold_row_in) * ProdW'(cfg.step_im);
   assign hold_valid_in = accept | (hold_valid_ff & ~queue_push);

   assign sum_re = SumW'(cfg.origin_re) + $signed(SumW'(prod_re_ff));
   assign sum_im = SumW'(cfg.origin_im) + $signed(SumW'(prod_im_ff));

   always_comb begin
      if (sum_re > QHi) begin
         c_re = QHi[DataW-1:0];
      end else if (sum_re < QLo) begin
         c_re = QLo[DataW-1:0];
      end else begin
         c_re = sum_re[DataW-1:0];
      end
      if (sum_im > QHi) begin
         c_im = QHi[DataW-1:0];
      end else if (sum_im < QLo) begin
         c_im = QLo[DataW-1:0];
      end else begin
         c_im = sum_im[DataW-1:0];
      end
   end

   assign queue_data = {c_re, c_im, hold_col_ff, hold_row_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_col_ff <= hold_col_in;
         hold_row_ff <= hold_row_in;
         prod_re_ff  <= prod_re_in;
         prod_im_ff  <= prod_im_in;
      end
   end

endmodule

@@ design/mbe_queue.sv @@
// Short first-in first-out queue between the front end and the iteration engine.
module mbe_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = mbe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import mbe_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PtrW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/mbe_back.sv @@
// Iteration engine: runs z = z*z + c for one point and drives the result register.
module mbe_back #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mbe_pkg::mbe_cfg_type cfg,
   input  logic                 queue_empty,
   output logic                 queue_pop,
   input  logic [2*(FRAC_BITS+4)+mbe_pkg::COL_W+mbe_pkg::ROW_W-1:0] queue_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mbe_pkg::mbe_rsp_type rsp_data
);
   import mbe_pkg::*;

   localparam int DataW = FRAC_BITS + 4;
   localparam int ProdW = 2 * DataW;
   localparam int SumW  = DataW + 2;
   localparam logic signed [SumW-1:0]  QHi = {3'b000, {(DataW-1){1'b1}}};
   localparam logic signed [SumW-1:0]  QLo = ~QHi;
   localparam logic signed [DataW-1:0] Two = {2'b00, 1'b1, {(FRAC_BITS+1){1'b0}}};
   localparam logic signed [DataW-1:0] NegTwo = -Two;
   localparam logic [DataW:0]          Four = {2'b00, 1'b1, {(FRAC_BITS+2){1'b0}}};

   mbe_back_state_type       state_ff, state_in;
   logic signed [DataW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [DataW-1:0]  c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [ProdW-1:0]  pxx_ff, pxx_in, pyy_ff, pyy_in, pxy_ff, pxy_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mbe_rsp_type              rsp_data_ff, rsp_data_in;
   logic                     rsp_load;
   logic                     x_big, y_big, escape;
   logic signed [DataW-1:0]  sq_x, sq_y;
   logic signed [DataW:0]    xy2;
   logic [DataW:0]           mag_sum;
   logic signed [SumW-1:0]   nx_sum, ny_sum;
   logic signed [DataW-1:0]  nx, ny;

   assign x_big = (x_ff > Two) || (x_ff < NegTwo);
   assign y_big = (y_ff > Two) || (y_ff < NegTwo);

   assign pxx_in = ProdW'(x_ff) * ProdW'(x_ff);
   assign pyy_in = ProdW'(y_ff) * ProdW'(y_ff);
   assign pxy_in = ProdW'(x_ff) * ProdW'(y_ff);

   // Products are floored by the arithmetic shift; 2xy keeps one more fraction bit.
   assign sq_x    = pxx_ff[FRAC_BITS+DataW-1:FRAC_BITS];
   assign sq_y    = pyy_ff[FRAC_BITS+DataW-1:FRAC_BITS];
   assign xy2     = pxy_ff[FRAC_BITS+DataW-1:FRAC_BITS-1];
   assign mag_sum = (DataW+1)'(sq_x) + (DataW+1)'(sq_y);
   assign escape  = (mag_sum > Four);
   assign nx_sum  = SumW'(sq_x) - SumW'(sq_y) + SumW'(c_re_ff);
   assign ny_sum  = SumW'(xy2) + SumW'(c_im_ff);

   always_comb begin
      if (nx_sum > QHi) begin
         nx = QHi[DataW-1:0];
      end else if (nx_sum < QLo) begin
         nx = QLo[DataW-1:0];
      end else begin
         nx = nx_sum[DataW-1:0];
      end
      if (ny_sum > QHi) begin
         ny = QHi[DataW-1:0];
      end else if (ny_sum < QLo) begin
         ny = QLo[DataW-1:0];
      end else begin
         ny = ny_sum[DataW-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      c_re_in     = c_re_ff;
      c_im_in     = c_im_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      count_in    = count_ff;
      queue_pop   = 1'b0;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               {c_re_in, c_im_in, col_in, row_in} = queue_data;
               x_in      = '0;
               y_in      = '0;
               count_in  = '0;
               state_in  = BACK_SQUARE;
            end
         end
         BACK_SQUARE: begin
            // The limit and the coarse bound are checked before the products are used.
            if (count_ff >= cfg.max_iterations || x_big || y_big) begin
               state_in = BACK_DONE;
            end else begin
               state_in = BACK_UPDATE;
            end
         end
         BACK_UPDATE: begin
            if (escape) begin
               state_in = BACK_DONE;
            end else begin
               x_in     = nx;
               y_in     = ny;
               count_in = count_ff + COUNT_W'(1);
               state_in = BACK_SQUARE;
            end
         end
         BACK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{out_column: col_ff, out_row: row_ff,
                               iteration_count: count_ff};
               state_in    = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      count_ff    <= count_in;
      pxx_ff      <= pxx_in;
      pyy_ff      <= pyy_in;
      pxy_ff      <= pxy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A new result only ever comes out of the completion state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BACK_DONE)
      else $error("result register loaded outside the completion state");

   // A completed point lands in the result register with its final count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_DONE && !(rsp_valid_ff && rsp_stall)
      |=> rsp_valid_ff && rsp_data_ff.iteration_count == $past(count_ff))
      else $error("completed point did not reach the result register");

   // Every update that does not escape adds exactly one to the count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_UPDATE && !escape
      |=> state_ff == BACK_SQUARE && count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("iteration count did not advance by one");

   // A point is taken only when the engine is free and work waits; it starts with a zero count.
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> state_ff == BACK_SQUARE && count_ff == '0)
      else $error("engine did not start cleanly on a new point");

endmodule

@@ test/mbe_escape_checker.sv @@
// Checker for the Mandelbrot escape-time core: mirrors the registers, predicts counts, compares.
module mbe_escape_checker #(
   parameter int FRAC = mbe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  mbe_pkg::mbe_req_type           req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  mbe_pkg::mbe_rsp_type           rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mbe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbe_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [mbe_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             error_count,
   output int                             pending,
   output int                             pixels_checked
);
   import mbe_pkg::*;

   mbe_cfg_type view;
   mbe_rsp_type expected_pixels[$];
   int          mismatches = 0;
   int          results_seen = 0;

   function automatic longint q_saturate(longint v);
      longint hi;
      hi = (longint'(1) << (FRAC + 3)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Number of z = z*z + c updates made before |z|^2 exceeds 4, capped at the limit.
   function automatic logic [COUNT_W-1:0] predict_escape(mbe_cfg_type v,
                                                         logic [COL_W-1:0] col,
                                                         logic [ROW_W-1:0] row);
      longint      two, four, c_re, c_im, x, y, sq_re, sq_im, nx, ny;
      int unsigned count;
      bit          escaped;
      two  = longint'(2) << FRAC;
      four = longint'(4) << FRAC;
      c_re = q_saturate(longint'($signed(v.origin_re)) + longint'(col) * longint'(v.step_re));
      c_im = q_saturate(longint'($signed(v.origin_im)) + longint'(row) * longint'(v.step_im));
      x = 0;
      y = 0;
      count = 0;
      escaped = 1'b0;
      while (!escaped && count < v.max_iterations) begin
         if ((x < 0 ? -x : x) > two || (y < 0 ? -y : y) > two) begin
            escaped = 1'b1;
         end else begin
            // Arithmetic shifts round each product toward minus infinity.
            sq_re = (x * x) >>> FRAC;
            sq_im = (y * y) >>> FRAC;
            if (sq_re + sq_im > four) begin
               escaped = 1'b1;
            end else begin
               nx = q_saturate(sq_re - sq_im + c_re);
               ny = q_saturate(((x * y) >>> (FRAC - 1)) + c_im);
               x = nx;
               y = ny;
               count++;
            end
         end
      end
      return count[COUNT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      mbe_rsp_type              want;
      logic [CSR_DATA_W-1:0]    read_value;
      bit                       known;
      if (reset) begin
         view.origin_re      = ORIGIN_RE_RESET;
         view.origin_im      = ORIGIN_IM_RESET;
         view.step_re        = STEP_RE_RESET;
         view.step_im        = STEP_IM_RESET;
         view.max_iterations = MAX_ITER_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            known = 1'b1;
            read_value = '0;
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_ORIGIN_RE: begin
                  if (csr_pwrite) view.origin_re = csr_pwdata;
                  read_value = view.origin_re;
               end
               REG_ORIGIN_IM: begin
                  if (csr_pwrite) view.origin_im = csr_pwdata;
                  read_value = view.origin_im;
               end
               REG_STEP_RE: begin
                  if (csr_pwrite) view.step_re = csr_pwdata[STEP_W-1:0];
                  read_value = {1'b0, view.step_re};
               end
               REG_STEP_IM: begin
                  if (csr_pwrite) view.step_im = csr_pwdata[STEP_W-1:0];
                  read_value = {1'b0, view.step_im};
               end
               REG_MAX_ITERATIONS: begin
                  if (csr_pwrite) view.max_iterations = csr_pwdata[COUNT_W-1:0];
                  read_value = {{(CSR_DATA_W-COUNT_W){1'b0}}, view.max_iterations};
               end
               default: known = 1'b0;
            endcase
            if (!csr_pwrite && known && csr_prdata !== read_value)
               report_mismatch($sformatf("register at 0x%02h read 0x%08h, expected 0x%08h",
                                         csr_paddr, csr_prdata, read_value));
         end

         if (req_valid && !req_stall) begin
            want.out_column      = req_data.column;
            want.out_row         = req_data.row;
            want.iteration_count = predict_escape(view, req_data.column, req_data.row);
            expected_pixels.push_back(want);
         end

         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result for column %0d row %0d with no request open",
                                         rsp_data.out_column, rsp_data.out_row));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_column !== want.out_column)
                  report_mismatch($sformatf("out_column %0d, expected %0d",
                                            rsp_data.out_column, want.out_column));
               if (rsp_data.out_row !== want.out_row)
                  report_mismatch($sformatf("out_row %0d, expected %0d",
                                            rsp_data.out_row, want.out_row));
               if (rsp_data.iteration_count !== want.iteration_count)
                  report_mismatch($sformatf("iteration_count %0d, expected %0d (pixel %0d,%0d)",
                                            rsp_data.iteration_count, want.iteration_count,
                                            want.out_column, want.out_row));
            end
         end
      end
      pending        <= expected_pixels.size();
      error_count    <= mismatches;
      pixels_checked <= results_seen;
   end

endmodule

@@ test/mandelbrot_escape_time_core_tb.sv @@
// Top of the Mandelbrot escape-time core testbench: clock, reset, stimulus and verdict.
module mandelbrot_escape_time_core_tb;
   import mbe_pkg::*;

   localparam int WATCHDOG_LIMIT = 600000;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 5'h14;

   localparam mbe_cfg_type DEFAULT_VIEW = '{
      origin_re: ORIGIN_RE_RESET, origin_im: ORIGIN_IM_RESET,
      step_re: STEP_RE_RESET, step_im: STEP_IM_RESET, max_iterations: MAX_ITER_RESET};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   mbe_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   mbe_rsp_type           rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int error_count;
   int pending;
   int pixels_checked;
   int send_idle_pct = 20;
   int recv_idle_pct = 72;
   int views_loaded = 0;
   bit hold_off_req = 1'b0;

   always #5 clock = ~clock;

   mandelbrot_escape_time_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mbe_escape_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .error_count    (error_count),
      .pending        (pending),
      .pixels_checked (pixels_checked)
   );

   // Result side: random stalls, plus one long hold-off that backs the core up.
   always @(posedge clock) begin : receiver
      int hold_left;
      bit hold_taken;
      if (hold_off_req && !hold_taken) begin
         hold_left  = HOLD_OFF_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: nothing moved on either channel for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(mbe_reg_type r);
      return {r, 2'b00};
   endfunction

   // A setup phase and an access phase held until ready, then the port is released.
   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_regs();
      csr_access(1'b0, reg_addr(REG_ORIGIN_RE), '0);
      csr_access(1'b0, reg_addr(REG_ORIGIN_IM), '0);
      csr_access(1'b0, reg_addr(REG_STEP_RE), '0);
      csr_access(1'b0, reg_addr(REG_STEP_IM), '0);
      csr_access(1'b0, reg_addr(REG_MAX_ITERATIONS), '0);
   endtask

   task automatic set_view(input mbe_cfg_type v);
      csr_access(1'b1, reg_addr(REG_ORIGIN_RE), v.origin_re);
      csr_access(1'b1, reg_addr(REG_ORIGIN_IM), v.origin_im);
      csr_access(1'b1, reg_addr(REG_STEP_RE), {1'b0, v.step_re});
      csr_access(1'b1, reg_addr(REG_STEP_IM), {1'b0, v.step_im});
      csr_access(1'b1, reg_addr(REG_MAX_ITERATIONS), {16'h0, v.max_iterations});
      read_all_regs();
      views_loaded++;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
   endtask

   // Valid stays high from one request to the next unless a gap is drawn.
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{column: col, row: row};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_pixels(input int count);
      repeat (count) send_pixel(COL_W'($urandom_range(MAX_COLUMNS - 1)),
                                ROW_W'($urandom_range(MAX_ROWS - 1)));
      drain();
   endtask

   initial begin : stimulus
      mbe_cfg_type v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      read_all_regs();

      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(1023, 0);
      send_pixel(0, 1023);
      // c = -2 lies on the boundary: |z|^2 settles at exactly 4 and never escapes.
      send_pixel(0, 512);
      send_pixel(512, 512);
      send_pixel(10'h155, 10'h2AA);
      send_pixel(10'h2AA, 10'h155);
      drain();

      // Zero steps with the lowest origin put c at the bottom corner of the range.
      set_view('{origin_re: 32'h8000_0000, origin_im: 32'h8000_0000,
                 step_re: '0, step_im: '0, max_iterations: MAX_ITER_RESET});
      send_pixel(1023, 1023);
      send_pixel(517, 3);
      drain();

      // Largest origin and step push c past the top of the range.
      set_view('{origin_re: 32'h7FFF_FFFF, origin_im: 32'h7FFF_FFFF,
                 step_re: 31'h7FFF_FFFF, step_im: 31'h7FFF_FFFF, max_iterations: 16'd64});
      send_pixel(1023, 1023);
      send_pixel(0, 0);
      drain();

      // Pixel (1,1) lands one step below zero and stays inside at the lowest limit.
      set_view('{origin_re: 32'h8000_0000, origin_im: 32'h8000_0000,
                 step_re: 31'h7FFF_FFFF, step_im: 31'h7FFF_FFFF, max_iterations: 16'd64});
      send_pixel(1, 1);
      send_pixel(2, 1);
      send_pixel(0, 0);
      drain();

      // A write past the last register must leave every register alone.
      csr_access(1'b1, SPARE_ADDR, '1);
      v = DEFAULT_VIEW;
      v.max_iterations = 16'hFFFF;
      set_view(v);
      send_pixel(0, 512);
      send_pixel(1023, 1023);
      drain();
      v.origin_re = '0;
      v.origin_im = '0;
      set_view(v);
      send_pixel(0, 0);
      drain();

      set_view(DEFAULT_VIEW);
      random_pixels(250);
      // Close view of the valley between the main bulbs, at the lowest limit.
      set_view('{origin_re: -32'sd214748365, origin_im: 32'sd13421773,
                 step_re: 31'd26214, step_im: 31'd26214, max_iterations: 16'd64});
      random_pixels(250);

      set_idling(72, 20);
      v.origin_re      = -32'sd671088640 + int'($urandom_range(0, 536870912));
      v.origin_im      = -32'sd335544320 + int'($urandom_range(0, 268435456));
      v.step_re        = STEP_W'($urandom_range(4096, 1048576));
      v.step_im        = STEP_W'($urandom_range(4096, 1048576));
      v.max_iterations = COUNT_W'($urandom_range(64, 256));
      set_view(v);
      random_pixels(250);
      set_view('{origin_re: 32'h8000_0000, origin_im: 32'h8000_0000,
                 step_re: 31'h7FFF_FFFF, step_im: 31'h7FFF_FFFF, max_iterations: 16'd300});
      random_pixels(250);

      set_idling(0, 0);
      set_view(DEFAULT_VIEW);
      hold_off_req = 1'b1;
      random_pixels(250);
      v.origin_re      = -32'sd671088640 + int'($urandom_range(0, 536870912));
      v.origin_im      = -32'sd335544320 + int'($urandom_range(0, 268435456));
      v.step_re        = STEP_W'($urandom_range(4096, 1048576));
      v.step_im        = STEP_W'($urandom_range(4096, 1048576));
      v.max_iterations = COUNT_W'($urandom_range(64, 256));
      set_view(v);
      random_pixels(250);

      // Leave room for any stray result the core might still emit.
      repeat (300) @(posedge clock);
      $display("Checked %0d pixel results across %0d register settings.",
               pixels_checked, views_loaded);
      $display("Covered saturated and boundary points, both iteration limits and back-pressure.");
      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
